FILE: src/radius_neighbor_finder_unit_assert.svh
// Assertion macros for the radius neighbor finder.
`ifndef RADIUS_NEIGHBOR_FINDER_UNIT_ASSERT_SVH
`define RADIUS_NEIGHBOR_FINDER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, clocked on clk, off during reset.
`define RNF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define RNF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RNF_ASSERT_SAME(lbl, ante, cons, msg)
`define RNF_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: src/rnf_pkg.sv
// Types and constants shared by the radius neighbor finder modules.
package rnf_pkg;

    localparam int NODE_W     = 10;
    localparam int IN_COORD_W = 16;
    localparam int DIST_W     = 34;
    localparam logic [DIST_W-1:0] DIST_RESET = 34'd16900;

    // Item kinds
    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_FOUND    = 2'd0;
    localparam logic [1:0] STAT_NONE     = 2'd1;
    localparam logic [1:0] STAT_UNLOADED = 2'd2;

    typedef struct packed {
        logic [1:0]                   kind;
        logic signed [IN_COORD_W-1:0] coord_x;
        logic signed [IN_COORD_W-1:0] coord_y;
        logic signed [IN_COORD_W-1:0] coord_z;
        logic [NODE_W-1:0]            query_node;
    } item_t;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] neighbor;
        logic [1:0]        status;
        logic              last;
    } result_t;

endpackage

FILE: src/radius_neighbor_finder_unit.sv
// Top level of the radius neighbor finder: point store, scan sequencer, result register.
//
// Item channel (item, item_valid, item_stall): clear, append or query transactions.
// A transaction is taken when item_valid is high and item_stall is low. Clear and
// append complete without leaving ST_IDLE; an append beyond MAX_POINTS points is
// dropped. A query reads the queried point, then streams every stored point
// through one memory read port and one squared-distance unit, one point per cycle
// unless result_stall holds a result. item_stall stays high for the whole query.
// Result channel (result, result_valid, result_stall): up to MAX_NEIGHBORS
// neighbor transactions per query, the final one marked by last; a query with no
// neighbor or an unloaded index gives one transaction. While result_stall holds
// a waiting result, the scan freezes in place and nothing is lost.
// Config channel (cfg_data, cfg_valid, cfg_ready): writes the squared radius.
// Reset empties the point set and sets the radius to 130 squared; point
// contents are not cleared.
module radius_neighbor_finder_unit
    import rnf_pkg::*;
#(
    parameter int MAX_POINTS    = 1024,
    parameter int MAX_NEIGHBORS = 15,
    parameter int COORD_BITS    = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  item_t             item,
    input  logic              item_valid,
    output logic              item_stall,
    output result_t           result,
    output logic              result_valid,
    input  logic              result_stall,
    input  logic [DIST_W-1:0] cfg_data,
    input  logic              cfg_valid,
    output logic              cfg_ready
);

`include "radius_neighbor_finder_unit_assert.svh"

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int HIT_W = $clog2(MAX_NEIGHBORS + 1);
    localparam int QW    = (CNT_W > NODE_W) ? CNT_W : NODE_W;
    localparam int PT_W  = 3 * COORD_BITS;
    localparam int EXT_W = (COORD_BITS > IN_COORD_W) ? COORD_BITS : IN_COORD_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOADQ,
        ST_LATCHQ,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [DIST_W-1:0]  max_dist_reg;
    logic [NODE_W-1:0]  q_reg, q_next;
    logic               err_reg, err_next;
    logic [PT_W-1:0]    qpt_reg, qpt_next;
    logic [CNT_W-1:0]   scan_idx_reg, scan_idx_next;
    logic               rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [HIT_W-1:0]   hits_reg, hits_next;
    logic               pend_vld_reg, pend_vld_next;
    logic [IDX_W-1:0]   pend_idx_reg, pend_idx_next;
    result_t            result_reg, result_next;
    logic               result_valid_reg, result_valid_next;

    // Point store
    logic [PT_W-1:0]    point_mem [MAX_POINTS];
    logic [PT_W-1:0]    rd_data_reg;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [PT_W-1:0]    wr_data;

    logic               item_take;
    logic               slot_free;
    logic               issuing;
    logic               dst_vld;
    logic [IDX_W-1:0]   dst_idx;
    logic               dst_hit;
    logic               hit_take;
    logic               last_hit;
    logic               scan_run;

    assign item_stall   = (state_reg != ST_IDLE);
    assign item_take    = item_valid && !item_stall;
    assign cfg_ready    = 1'b1;
    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    // Output slot can take a new transaction this cycle
    assign slot_free = !result_valid_reg || !result_stall;
    assign scan_run  = (state_reg == ST_SCAN) && slot_free;
    assign issuing   = (state_reg == ST_SCAN) && (scan_idx_reg != count_reg);

    // Append write data: sign-extend then keep COORD_BITS per axis
    always_comb
    begin
        logic signed [EXT_W-1:0] ex;
        logic signed [EXT_W-1:0] ey;
        logic signed [EXT_W-1:0] ez;
        ex = EXT_W'(item.coord_x);
        ey = EXT_W'(item.coord_y);
        ez = EXT_W'(item.coord_z);
        wr_data = {ez[COORD_BITS-1:0], ey[COORD_BITS-1:0], ex[COORD_BITS-1:0]};
    end

    assign wr_en   = item_take && (item.kind == KIND_APPEND)
                   && (count_reg != CNT_W'(MAX_POINTS));
    assign rd_en   = (state_reg == ST_LOADQ) || (issuing && slot_free);
    assign rd_addr = (state_reg == ST_LOADQ) ? IDX_W'(q_reg) : scan_idx_reg[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            point_mem[count_reg[IDX_W-1:0]] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= point_mem[rd_addr];
        end
    end

    // Distance unit shared by every scanned point
    rnf_dist #(
        .COORD_BITS (COORD_BITS),
        .IDX_W      (IDX_W)
    ) u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (scan_run),
        .kill    (last_hit),
        .vld     (rd_vld_reg),
        .idx     (rd_idx_reg),
        .pt_a    (qpt_reg),
        .pt_b    (rd_data_reg),
        .limit   (max_dist_reg),
        .dst_vld (dst_vld),
        .dst_idx (dst_idx),
        .dst_hit (dst_hit)
    );

    // A neighbor is taken when in range and not the queried point itself
    assign hit_take = scan_run && dst_vld && dst_hit && (QW'(dst_idx) != QW'(q_reg));
    assign last_hit = hit_take && (hits_reg == HIT_W'(MAX_NEIGHBORS - 1));

    // Sequencer next state
    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        q_next            = q_reg;
        err_next          = err_reg;
        qpt_next          = qpt_reg;
        scan_idx_next     = scan_idx_reg;
        rd_vld_next       = rd_vld_reg;
        rd_idx_next       = rd_idx_reg;
        hits_next         = hits_reg;
        pend_vld_next     = pend_vld_reg;
        pend_idx_next     = pend_idx_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_take)
                begin
                    unique case (item.kind)
                        KIND_CLEAR:
                        begin
                            count_next = '0;
                        end
                        KIND_APPEND:
                        begin
                            if (count_reg != CNT_W'(MAX_POINTS))
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        KIND_QUERY:
                        begin
                            q_next        = item.query_node;
                            hits_next     = '0;
                            pend_vld_next = 1'b0;
                            scan_idx_next = '0;
                            rd_vld_next   = 1'b0;
                            if (QW'(item.query_node) >= QW'(count_reg))
                            begin
                                err_next   = 1'b1;
                                state_next = ST_FINISH;
                            end
                            else
                            begin
                                err_next   = 1'b0;
                                state_next = ST_LOADQ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_LOADQ:
            begin
                state_next = ST_LATCHQ;
            end
            ST_LATCHQ:
            begin
                qpt_next   = rd_data_reg;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (slot_free)
                begin
                    rd_vld_next = issuing;
                    rd_idx_next = scan_idx_reg[IDX_W-1:0];
                    if (issuing)
                    begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end
                if (hit_take)
                begin
                    // Older pending neighbor goes out; newest one waits for its last flag
                    if (pend_vld_reg)
                    begin
                        result_next.node     = q_reg;
                        result_next.neighbor = NODE_W'(pend_idx_reg);
                        result_next.status   = STAT_FOUND;
                        result_next.last     = 1'b0;
                        result_valid_next    = 1'b1;
                    end
                    pend_vld_next = 1'b1;
                    pend_idx_next = dst_idx;
                    hits_next     = hits_reg + 1'b1;
                    if (last_hit)
                    begin
                        rd_vld_next = 1'b0;
                        state_next  = ST_FINISH;
                    end
                end
                else if (!issuing && !rd_vld_reg && !dst_vld)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    result_next.node  = q_reg;
                    result_next.last  = 1'b1;
                    result_valid_next = 1'b1;
                    if (err_reg)
                    begin
                        result_next.neighbor = '0;
                        result_next.status   = STAT_UNLOADED;
                    end
                    else if (pend_vld_reg)
                    begin
                        result_next.neighbor = NODE_W'(pend_idx_reg);
                        result_next.status   = STAT_FOUND;
                    end
                    else
                    begin
                        result_next.neighbor = '0;
                        result_next.status   = STAT_NONE;
                    end
                    pend_vld_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            max_dist_reg     <= DIST_RESET;
            q_reg            <= '0;
            err_reg          <= 1'b0;
            qpt_reg          <= '0;
            scan_idx_reg     <= '0;
            rd_vld_reg       <= 1'b0;
            rd_idx_reg       <= '0;
            hits_reg         <= '0;
            pend_vld_reg     <= 1'b0;
            pend_idx_reg     <= '0;
            result_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            q_reg            <= q_next;
            err_reg          <= err_next;
            qpt_reg          <= qpt_next;
            scan_idx_reg     <= scan_idx_next;
            rd_vld_reg       <= rd_vld_next;
            rd_idx_reg       <= rd_idx_next;
            hits_reg         <= hits_next;
            pend_vld_reg     <= pend_vld_next;
            pend_idx_reg     <= pend_idx_next;
            result_reg       <= result_next;
            result_valid_reg <= result_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                max_dist_reg <= cfg_data;
            end
        end
    end

    // Checks
    `RNF_ASSERT_SAME(a_hits_bound, 1'b1, hits_reg <= HIT_W'(MAX_NEIGHBORS),
        "neighbor count exceeds limit")
    `RNF_ASSERT_SAME(a_pend_has_hit, pend_vld_reg, hits_reg != '0,
        "pending neighbor without a counted hit")
    `RNF_ASSERT_SAME(a_scan_in_range, state_reg == ST_SCAN, scan_idx_reg <= count_reg,
        "scan index past point count")
    `RNF_ASSERT_NEXT(a_finish_emits, (state_reg == ST_FINISH) && slot_free,
        (state_reg == ST_IDLE) && result_valid_reg && result_reg.last,
        "query finish did not emit final result")

endmodule

FILE: src/rnf_dist.sv
// Squared-distance stage: per-axis squares registered, then sum and radius compare.
module rnf_dist
    import rnf_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int IDX_W      = 10
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    kill,
    input  logic                    vld,
    input  logic [IDX_W-1:0]        idx,
    input  logic [3*COORD_BITS-1:0] pt_a,
    input  logic [3*COORD_BITS-1:0] pt_b,
    input  logic [DIST_W-1:0]       limit,
    output logic                    dst_vld,
    output logic [IDX_W-1:0]        dst_idx,
    output logic                    dst_hit
);

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int SQ_W   = 2 * COORD_BITS + 1;
    localparam int SUM_W  = SQ_W + 2;
    localparam int CMP_W  = (SUM_W > DIST_W) ? SUM_W : DIST_W;

    logic [SQ_W-1:0]   sq_next [3];
    logic [SQ_W-1:0]   sq_reg  [3];
    logic              vld_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [SUM_W-1:0]  sum;

    // Per-axis difference magnitude and square
    always_comb
    begin
        logic signed [DIFF_W-1:0] diff;
        logic [DIFF_W-1:0]        mag;
        logic [2*DIFF_W-1:0]      prod;
        for (int a = 0; a < 3; a++)
        begin
            diff = $signed({pt_a[a*COORD_BITS + COORD_BITS-1], pt_a[a*COORD_BITS +: COORD_BITS]})
                 - $signed({pt_b[a*COORD_BITS + COORD_BITS-1], pt_b[a*COORD_BITS +: COORD_BITS]});
            mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
            prod = mag * mag;
            sq_next[a] = prod[SQ_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            idx_reg <= '0;
            for (int a = 0; a < 3; a++)
            begin
                sq_reg[a] <= '0;
            end
        end
        else if (kill)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld;
            idx_reg <= idx;
            for (int a = 0; a < 3; a++)
            begin
                sq_reg[a] <= sq_next[a];
            end
        end
    end

    // Sum of squares against the radius limit
    assign sum = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);

    assign dst_vld = vld_reg;
    assign dst_idx = idx_reg;
    assign dst_hit = (CMP_W'(sum) <= CMP_W'(limit));

endmodule
